[src/mdp_pkg.sv]
// Shared constants, types and command struct of the minimum-difference pair finder.
package mdp_pkg;

   localparam int SET_DEPTH = 1024;
   localparam int ADDR_W    = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
   localparam int CNT_W     = $clog2(SET_DEPTH + 1);

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [CNT_W-1:0]  cnt_type;

   localparam logic [1:0] REQ_LOAD_A = 2'd0;
   localparam logic [1:0] REQ_LOAD_B = 2'd1;
   localparam logic [1:0] REQ_FIND   = 2'd2;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_EMPTY   = 2'd1,
      STATUS_DROPPED = 2'd2
   } status_type;

   typedef struct packed {
      logic       wr_a;
      logic       wr_b;
      addr_type   wr_addr;
      logic       ref_b;
      addr_type   ref_addr;
      addr_type   oth_addr;
      logic       mm_step;
      logic       mm_first;
      logic       oth0_load;
      logic       tgt_load;
      logic       ps_step;
      logic       ps_first;
      logic       init_best;
      logic       calc_mid;
      logic       calc_pick;
      logic       calc_diff;
      logic       calc_update;
      logic       rsp_load;
      status_type rsp_status;
   } cmd_type;

endpackage

[src/mdp_if.sv]
// Valid/ready channel interfaces for requests and responses.
interface mdp_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        req_type;
   logic signed [31:0] elem_value;

   modport source (output valid, output req_type, output elem_value, input ready);
   modport sink   (input valid, input req_type, input elem_value, output ready);
endinterface

interface mdp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pair_from_reference;
   logic signed [31:0] pair_from_other;
   logic [31:0]        pair_difference;
   logic               reference_is_b;
   logic [1:0]         status;

   modport source (output valid, output pair_from_reference, output pair_from_other,
                   output pair_difference, output reference_is_b, output status,
                   input ready);
   modport sink   (input valid, input pair_from_reference, input pair_from_other,
                   input pair_difference, input reference_is_b, input status,
                   output ready);
endinterface

[src/mdp_datapath.sv]
// Datapath: set memories, min/max and predecessor/successor scan, best-pair registers.
module mdp_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  mdp_pkg::cmd_type        cmd,
   input  logic signed [31:0]      elem_value,
   output logic signed [31:0]      pair_from_reference,
   output logic signed [31:0]      pair_from_other,
   output logic [31:0]             pair_difference,
   output logic                    reference_is_b,
   output logic [1:0]              status
);

   logic signed [31:0] mem_a [mdp_pkg::SET_DEPTH];
   logic signed [31:0] mem_b [mdp_pkg::SET_DEPTH];

   mdp_pkg::addr_type  a_addr;
   mdp_pkg::addr_type  b_addr;
   logic signed [31:0] a_q_ff;
   logic signed [31:0] b_q_ff;
   mdp_pkg::cmd_type   cmd_d_ff;

   logic signed [31:0] ref_q;
   logic signed [31:0] oth_q;

   logic signed [31:0] lo_ff, lo_in;
   logic signed [31:0] hi_ff, hi_in;
   logic signed [31:0] oth0_ff, oth0_in;
   logic signed [31:0] target_ff, target_in;
   logic signed [31:0] pred_ff, pred_in;
   logic signed [31:0] succ_ff, succ_in;
   logic               has_pred_ff, has_pred_in;
   logic               has_succ_ff, has_succ_in;
   logic signed [32:0] mid_ff, mid_in;
   logic signed [31:0] cand_ff, cand_in;
   logic [31:0]        diff_ff, diff_in;
   logic signed [31:0] best_r_ff, best_r_in;
   logic signed [31:0] best_o_ff, best_o_in;
   logic [31:0]        best_d_ff, best_d_in;
   logic signed [31:0] rsp_r_ff, rsp_r_in;
   logic signed [31:0] rsp_o_ff, rsp_o_in;
   logic [31:0]        rsp_d_ff, rsp_d_in;
   logic               rsp_b_ff, rsp_b_in;
   logic [1:0]         rsp_s_ff, rsp_s_in;

   logic signed [32:0] sum;
   logic signed [32:0] rnd;
   logic               p_prev;
   logic               s_prev;
   logic               take_pred;
   logic               take_succ;

   function automatic logic [31:0] abs_diff(input logic signed [31:0] x,
                                            input logic signed [31:0] y);
      logic signed [32:0] dpos;
      logic signed [32:0] dneg;
      dpos = {x[31], x} - {y[31], y};
      dneg = {y[31], y} - {x[31], x};
      return dpos[32] ? dneg[31:0] : dpos[31:0];
   endfunction

   assign a_addr = cmd.ref_b ? cmd.oth_addr : cmd.ref_addr;
   assign b_addr = cmd.ref_b ? cmd.ref_addr : cmd.oth_addr;

   always_ff @(posedge clock) begin
      if (cmd.wr_a) begin
         mem_a[cmd.wr_addr] <= elem_value;
      end
      a_q_ff <= mem_a[a_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_b) begin
         mem_b[cmd.wr_addr] <= elem_value;
      end
      b_q_ff <= mem_b[b_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_d_ff <= '0;
      end else begin
         cmd_d_ff <= cmd;
      end
   end

   assign ref_q = cmd_d_ff.ref_b ? b_q_ff : a_q_ff;
   assign oth_q = cmd_d_ff.ref_b ? a_q_ff : b_q_ff;

   always_comb begin
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      oth0_in     = oth0_ff;
      target_in   = target_ff;
      pred_in     = pred_ff;
      succ_in     = succ_ff;
      has_pred_in = has_pred_ff;
      has_succ_in = has_succ_ff;
      mid_in      = mid_ff;
      cand_in     = cand_ff;
      diff_in     = diff_ff;
      best_r_in   = best_r_ff;
      best_o_in   = best_o_ff;
      best_d_in   = best_d_ff;
      rsp_r_in    = rsp_r_ff;
      rsp_o_in    = rsp_o_ff;
      rsp_d_in    = rsp_d_ff;
      rsp_b_in    = rsp_b_ff;
      rsp_s_in    = rsp_s_ff;

      p_prev    = has_pred_ff && !cmd_d_ff.ps_first;
      s_prev    = has_succ_ff && !cmd_d_ff.ps_first;
      take_pred = (ref_q <= target_ff) && (!p_prev || (ref_q > pred_ff));
      take_succ = (ref_q >= target_ff) && (!s_prev || (ref_q < succ_ff));

      sum = {pred_ff[31], pred_ff} + {succ_ff[31], succ_ff};
      rnd = sum + $signed({32'b0, sum[32]});

      if (cmd_d_ff.mm_step) begin
         if (cmd_d_ff.mm_first || (ref_q < lo_ff)) begin
            lo_in = ref_q;
         end
         if (cmd_d_ff.mm_first || (ref_q > hi_ff)) begin
            hi_in = ref_q;
         end
      end
      if (cmd_d_ff.oth0_load) begin
         oth0_in = oth_q;
      end
      if (cmd_d_ff.tgt_load) begin
         target_in = oth_q;
      end
      if (cmd_d_ff.ps_step) begin
         has_pred_in = p_prev || take_pred;
         has_succ_in = s_prev || take_succ;
         if (take_pred) begin
            pred_in = ref_q;
         end
         if (take_succ) begin
            succ_in = ref_q;
         end
      end

      if (cmd.init_best) begin
         best_r_in = lo_ff;
         best_o_in = oth0_ff;
         best_d_in = abs_diff(lo_ff, oth0_ff);
      end
      if (cmd.calc_mid) begin
         mid_in = {rnd[32], rnd[32:1]};
      end
      if (cmd.calc_pick) begin
         if (target_ff > hi_ff) begin
            cand_in = hi_ff;
         end else if (target_ff < lo_ff) begin
            cand_in = lo_ff;
         end else if (pred_ff == target_ff) begin
            cand_in = target_ff;
         end else if ($signed({target_ff[31], target_ff}) <= mid_ff) begin
            cand_in = pred_ff;
         end else begin
            cand_in = succ_ff;
         end
      end
      if (cmd.calc_diff) begin
         diff_in = abs_diff(cand_ff, target_ff);
      end
      if (cmd.calc_update && (diff_ff < best_d_ff)) begin
         best_d_in = diff_ff;
         best_r_in = cand_ff;
         best_o_in = target_ff;
      end

      if (cmd.rsp_load) begin
         rsp_s_in = cmd.rsp_status;
         if (cmd.rsp_status == mdp_pkg::STATUS_EMPTY) begin
            rsp_r_in = '0;
            rsp_o_in = '0;
            rsp_d_in = '0;
            rsp_b_in = 1'b0;
         end else begin
            rsp_r_in = best_r_ff;
            rsp_o_in = best_o_ff;
            rsp_d_in = best_d_ff;
            rsp_b_in = cmd.ref_b;
         end
      end
   end

   always_ff @(posedge clock) begin
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      oth0_ff     <= oth0_in;
      target_ff   <= target_in;
      pred_ff     <= pred_in;
      succ_ff     <= succ_in;
      has_pred_ff <= has_pred_in;
      has_succ_ff <= has_succ_in;
      mid_ff      <= mid_in;
      cand_ff     <= cand_in;
      diff_ff     <= diff_in;
      best_r_ff   <= best_r_in;
      best_o_ff   <= best_o_in;
      best_d_ff   <= best_d_in;
      rsp_r_ff    <= rsp_r_in;
      rsp_o_ff    <= rsp_o_in;
      rsp_d_ff    <= rsp_d_in;
      rsp_b_ff    <= rsp_b_in;
      rsp_s_ff    <= rsp_s_in;
   end

   assign pair_from_reference = rsp_r_ff;
   assign pair_from_other     = rsp_o_ff;
   assign pair_difference     = rsp_d_ff;
   assign reference_is_b      = rsp_b_ff;
   assign status              = rsp_s_ff;

endmodule

[src/mdp_controller.sv]
// Controller: set counts, scan sequencing and response handshake.
module mdp_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [1:0]       req_type,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mdp_pkg::cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_MM,
      S_MM_DRAIN,
      S_INIT,
      S_OTH,
      S_SCAN,
      S_SCAN_DRAIN,
      S_MID,
      S_PICK,
      S_DIFF,
      S_UPD,
      S_FIN
   } state_type;

   state_type            state_ff, state_in;
   mdp_pkg::cnt_type     count_a_ff, count_a_in;
   mdp_pkg::cnt_type     count_b_ff, count_b_in;
   logic                 dropped_ff, dropped_in;
   logic                 ref_b_ff, ref_b_in;
   mdp_pkg::status_type  status_ff, status_in;
   mdp_pkg::addr_type    i_ff, i_in;
   mdp_pkg::addr_type    j_ff, j_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   mdp_pkg::cnt_type     nr;
   mdp_pkg::cnt_type     no;
   logic                 last_j;
   logic                 last_i;
   logic                 fin_go;
   logic                 a_full;
   logic                 b_full;

   assign nr     = ref_b_ff ? count_b_ff : count_a_ff;
   assign no     = ref_b_ff ? count_a_ff : count_b_ff;
   assign last_j = (mdp_pkg::cnt_type'(j_ff) + mdp_pkg::cnt_type'(1)) == nr;
   assign last_i = (mdp_pkg::cnt_type'(i_ff) + mdp_pkg::cnt_type'(1)) == no;
   assign fin_go = !rsp_valid_ff || rsp_ready;
   assign a_full = count_a_ff == mdp_pkg::cnt_type'(mdp_pkg::SET_DEPTH);
   assign b_full = count_b_ff == mdp_pkg::cnt_type'(mdp_pkg::SET_DEPTH);

   always_comb begin
      state_in     = state_ff;
      count_a_in   = count_a_ff;
      count_b_in   = count_b_ff;
      dropped_in   = dropped_ff;
      ref_b_in     = ref_b_ff;
      status_in    = status_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      cmd            = '0;
      cmd.ref_b      = ref_b_ff;
      cmd.ref_addr   = j_ff;
      cmd.oth_addr   = i_ff;
      cmd.rsp_status = status_ff;
      cmd.wr_addr    = (req_type == mdp_pkg::REQ_LOAD_A) ? count_a_ff[mdp_pkg::ADDR_W-1:0]
                                                          : count_b_ff[mdp_pkg::ADDR_W-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (req_type)
                  mdp_pkg::REQ_LOAD_A: begin
                     if (!a_full) begin
                        cmd.wr_a   = 1'b1;
                        count_a_in = count_a_ff + mdp_pkg::cnt_type'(1);
                     end else begin
                        dropped_in = 1'b1;
                     end
                  end
                  mdp_pkg::REQ_LOAD_B: begin
                     if (!b_full) begin
                        cmd.wr_b   = 1'b1;
                        count_b_in = count_b_ff + mdp_pkg::cnt_type'(1);
                     end else begin
                        dropped_in = 1'b1;
                     end
                  end
                  mdp_pkg::REQ_FIND: begin
                     i_in = '0;
                     j_in = '0;
                     if ((count_a_ff == '0) || (count_b_ff == '0)) begin
                        status_in = mdp_pkg::STATUS_EMPTY;
                        ref_b_in  = 1'b0;
                        state_in  = S_FIN;
                     end else begin
                        status_in = dropped_ff ? mdp_pkg::STATUS_DROPPED : mdp_pkg::STATUS_OK;
                        ref_b_in  = count_b_ff < count_a_ff;
                        state_in  = S_MM;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_MM: begin
            cmd.mm_step   = 1'b1;
            cmd.mm_first  = j_ff == '0;
            cmd.oth0_load = j_ff == '0;
            if (last_j) begin
               j_in     = '0;
               state_in = S_MM_DRAIN;
            end else begin
               j_in = j_ff + mdp_pkg::addr_type'(1);
            end
         end
         S_MM_DRAIN: begin
            state_in = S_INIT;
         end
         S_INIT: begin
            cmd.init_best = 1'b1;
            state_in      = S_OTH;
         end
         S_OTH: begin
            cmd.tgt_load = 1'b1;
            j_in         = '0;
            state_in     = S_SCAN;
         end
         S_SCAN: begin
            cmd.ps_step  = 1'b1;
            cmd.ps_first = j_ff == '0;
            if (last_j) begin
               j_in     = '0;
               state_in = S_SCAN_DRAIN;
            end else begin
               j_in = j_ff + mdp_pkg::addr_type'(1);
            end
         end
         S_SCAN_DRAIN: begin
            state_in = S_MID;
         end
         S_MID: begin
            cmd.calc_mid = 1'b1;
            state_in     = S_PICK;
         end
         S_PICK: begin
            cmd.calc_pick = 1'b1;
            state_in      = S_DIFF;
         end
         S_DIFF: begin
            cmd.calc_diff = 1'b1;
            state_in      = S_UPD;
         end
         S_UPD: begin
            cmd.calc_update = 1'b1;
            if (last_i) begin
               state_in = S_FIN;
            end else begin
               i_in     = i_ff + mdp_pkg::addr_type'(1);
               state_in = S_OTH;
            end
         end
         S_FIN: begin
            if (fin_go) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               count_a_in   = '0;
               count_b_in   = '0;
               dropped_in   = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_a_ff   <= '0;
         count_b_ff   <= '0;
         dropped_ff   <= 1'b0;
         ref_b_ff     <= 1'b0;
         status_ff    <= mdp_pkg::STATUS_OK;
         i_ff         <= '0;
         j_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_a_ff   <= count_a_in;
         count_b_ff   <= count_b_in;
         dropped_ff   <= dropped_in;
         ref_b_ff     <= ref_b_in;
         status_ff    <= status_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   ap_count_bound: assert property (@(posedge clock) disable iff (reset)
      (count_a_ff <= mdp_pkg::cnt_type'(mdp_pkg::SET_DEPTH)) &&
      (count_b_ff <= mdp_pkg::cnt_type'(mdp_pkg::SET_DEPTH)))
      else $error("Set count exceeds the store depth.");

   ap_scan_sets_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MM || state_ff == S_SCAN || state_ff == S_UPD) |->
      ((count_a_ff != '0) && (count_b_ff != '0)))
      else $error("A search step runs with an empty set.");

   ap_scan_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN || state_ff == S_MM) |-> (mdp_pkg::cnt_type'(j_ff) < nr))
      else $error("Reference scan index runs past the set count.");

   ap_clear_after_find: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && fin_go) |=>
      ((count_a_ff == '0) && (count_b_ff == '0) && !dropped_ff && rsp_valid_ff))
      else $error("Sets not cleared or response not raised after a find.");

endmodule

[src/min_difference_pair_finder.sv]
// Top level of the minimum-difference pair finder.
// Usage: the request channel carries load-A, load-B and find transfers; the
// response channel carries one result per find and nothing for loads.
// Loads stream in at one per cycle while no find runs; a load into a full
// set is dropped and flagged in the status of the next find, unless that
// find reports an empty set. A find takes the smaller set as reference (set
// A on a tie) and scans it with a single read port per store: one min/max
// pass, then for each element of the other set a pass over the reference
// set. A find with an empty set answers without a scan. While a find runs,
// no request is taken. After each find both sets are empty again.
// The result sits in an output register; loads keep being taken while it
// waits, and a following find finishes its search and then holds until the
// receiver has taken the earlier result.
// Reset (synchronous, active high) empties both sets, clears the drop flag
// and drops any pending response; store contents are not cleared.
module min_difference_pair_finder (
   input logic       clock,
   input logic       reset,
   mdp_req_if.sink   req_ch,
   mdp_rsp_if.source rsp_ch
);

   mdp_pkg::cmd_type cmd;

   mdp_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_type  (req_ch.req_type),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   mdp_datapath u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .elem_value          (req_ch.elem_value),
      .pair_from_reference (rsp_ch.pair_from_reference),
      .pair_from_other     (rsp_ch.pair_from_other),
      .pair_difference     (rsp_ch.pair_difference),
      .reference_is_b      (rsp_ch.reference_is_b),
      .status              (rsp_ch.status)
   );

endmodule
